FILE: rtl/pcd_pkg.sv
// ----------------------------------------------------------------------------
// Pump command parser package
// Shared types, codes and keyword tables for the pump command parser.
// ----------------------------------------------------------------------------
package pcd_pkg;

  localparam int PCD_MAX_PACKET_BYTES = 32;
  localparam logic [15:0] PCD_MAX_SECONDS_RESET = 16'd180;
  localparam logic [15:0] PCD_FIELD_SAT = 16'hFFFF;
  localparam int PCD_NUM_KW = 5;

  // Keyword slots in the candidate vector.
  localparam int KW_PING   = 0;
  localparam int KW_STATUS = 1;
  localparam int KW_POLL   = 2;
  localparam int KW_RUN    = 3;
  localparam int KW_OFF    = 4;

  // Keyword text, padded with zeros to eight characters.
  localparam logic [7:0] KW_TEXT [PCD_NUM_KW][8] = '{
    '{"P", "I", "N", "G", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "T", "A", "T", "U", "S", 8'h00, 8'h00},
    '{"P", "O", "L", "L", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"R", "U", "N", ",", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"O", "F", "F", ",", 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [PCD_NUM_KW] = '{3'd4, 3'd6, 3'd4, 3'd4, 3'd4};

  typedef enum logic [2:0] {
    PH_KEY  = 3'd0,
    PH_RUN0 = 3'd1,
    PH_RUN1 = 3'd2,
    PH_RUN2 = 3'd3,
    PH_OFF0 = 3'd4,
    PH_OFF1 = 3'd5,
    PH_NONE = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_OFF  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    RESP_PONG     = 4'd0,
    RESP_STATUS   = 4'd1,
    RESP_BAD_CMD  = 4'd2,
    RESP_BAD_TIME = 4'd3,
    RESP_DUP      = 4'd4,
    RESP_CONFLICT = 4'd5,
    RESP_ACK_RUN  = 4'd6,
    RESP_ACK_OFF  = 4'd7,
    RESP_UNKNOWN  = 4'd8
  } resp_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } action_t;

  typedef struct packed {
    logic [7:0]  cmd_byte;
    logic        last_byte;
    logic        pump_on;
    logic [15:0] pump_remaining;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  response_code;
    logic [15:0] session_num;
    logic [15:0] message_num;
    logic [15:0] run_seconds;
    logic        pump_on_report;
    logic [15:0] remaining_report;
    logic [1:0]  pump_action;
  } out_item_t;

  // Parse state as it stands after the current byte has been taken.
  typedef struct packed {
    phase_t                  phase;
    logic [PCD_NUM_KW-1:0]   cands;
    logic                    bad;
    logic [15:0]             accum;
    logic [15:0]             session;
    logic [15:0]             message;
    logic                    pos_is4;
    logic                    pos_is6;
  } parse_t;

endpackage

FILE: rtl/pcd_parser.sv
// ----------------------------------------------------------------------------
// Pump command byte parser
// Keeps the per-packet parse state and folds in one text byte per transfer.
// ----------------------------------------------------------------------------
module pcd_parser import pcd_pkg::*; #(
  parameter int MaxBytes = PCD_MAX_PACKET_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       clear,
  input  logic [7:0] cmd_byte,
  output parse_t     post
);

  localparam int PW = $clog2(MaxBytes + 1);

  phase_t                phase, phase_next;
  logic [PW-1:0]         pos, pos_next;
  logic [PCD_NUM_KW-1:0] cands, cands_next;
  logic                  ended, ended_next;
  logic                  bad, bad_next;
  logic [15:0]           accum, accum_next;
  logic [15:0]           session, session_next;
  logic [15:0]           message, message_next;
  logic [19:0]           times_ten;
  logic [19:0]           digit_sum;
  logic                  is_digit;

  assign is_digit  = (cmd_byte >= "0") && (cmd_byte <= "9");
  assign times_ten = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0};
  assign digit_sum = times_ten + {16'd0, cmd_byte[3:0]};

  always_comb begin
    phase_next   = phase;
    pos_next     = pos;
    cands_next   = cands;
    ended_next   = ended;
    bad_next     = bad;
    accum_next   = accum;
    session_next = session;
    message_next = message;
    if (!ended && (pos < PW'(MaxBytes))) begin
      if (cmd_byte == 8'h00) begin
        ended_next = 1'b1;
      end else begin
        pos_next = pos + PW'(1);
        if (phase == PH_KEY) begin
          for (int k = 0; k < PCD_NUM_KW; k++) begin
            if (cands[k] && !((pos < PW'(KW_LEN[k])) && (cmd_byte == KW_TEXT[k][pos[2:0]])))
              cands_next[k] = 1'b0;
          end
          if ((pos == PW'(3)) && cands_next[KW_RUN]) begin
            phase_next = PH_RUN0;
            accum_next = 16'd0;
          end else if ((pos == PW'(3)) && cands_next[KW_OFF]) begin
            phase_next = PH_OFF0;
            accum_next = 16'd0;
          end else if (cands_next == '0) begin
            phase_next = PH_NONE;
          end
        end else if ((phase != PH_NONE) && !bad) begin
          if (is_digit) begin
            accum_next = (|digit_sum[19:16]) ? PCD_FIELD_SAT : digit_sum[15:0];
          end else if (cmd_byte == ",") begin
            accum_next = 16'd0;
            case (phase)
              PH_RUN0: begin
                session_next = accum;
                phase_next   = PH_RUN1;
              end
              PH_RUN1: begin
                message_next = accum;
                phase_next   = PH_RUN2;
              end
              PH_OFF0: begin
                session_next = accum;
                phase_next   = PH_OFF1;
              end
              default: begin
                // A comma after the final field is a format error.
                bad_next   = 1'b1;
                accum_next = accum;
              end
            endcase
          end else begin
            bad_next = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    post.phase   = phase_next;
    post.cands   = cands_next;
    post.bad     = bad_next;
    post.accum   = accum_next;
    post.session = session_next;
    post.message = message_next;
    post.pos_is4 = (pos_next == PW'(4));
    post.pos_is6 = (pos_next == PW'(6));
  end

  always_ff @(posedge clk) begin
    if (rst || (en && clear)) begin
      phase   <= PH_KEY;
      pos     <= '0;
      cands   <= '1;
      ended   <= 1'b0;
      bad     <= 1'b0;
      accum   <= 16'd0;
      session <= 16'd0;
      message <= 16'd0;
    end else if (en) begin
      phase   <= phase_next;
      pos     <= pos_next;
      cands   <= cands_next;
      ended   <= ended_next;
      bad     <= bad_next;
      accum   <= accum_next;
      session <= session_next;
      message <= message_next;
    end
  end

endmodule

FILE: rtl/pcd_decide.sv
// ----------------------------------------------------------------------------
// Pump command decision
// Classifies a finished packet and keeps the last accepted command.
// ----------------------------------------------------------------------------
module pcd_decide import pcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        commit,
  input  parse_t      post,
  input  logic        pump_on,
  input  logic [15:0] pump_remaining,
  input  logic [15:0] max_seconds,
  output logic        res_valid,
  output out_item_t   result
);

  logic        have_last;
  logic [15:0] last_session;
  logic [15:0] last_message;
  kind_t       last_kind;
  logic [15:0] last_duration;

  logic        same_ids;
  logic        store;
  kind_t       store_kind;

  assign same_ids = have_last && (post.session == last_session) &&
                    (post.message == last_message);

  // For OFF the message field is still in the accumulator at the last byte.
  logic [15:0] off_message;
  logic        off_same;
  assign off_message = post.accum;
  assign off_same    = have_last && (post.session == last_session) &&
                       (off_message == last_message);

  always_comb begin
    res_valid  = 1'b1;
    result     = '0;
    store      = 1'b0;
    store_kind = KIND_NONE;
    unique case (post.phase) inside
      PH_KEY: begin
        if (post.cands[KW_PING] && post.pos_is4) begin
          result.response_code = RESP_PONG;
        end else if (post.cands[KW_STATUS] && post.pos_is6) begin
          result.response_code    = RESP_STATUS;
          result.pump_on_report   = pump_on;
          result.remaining_report = pump_on ? pump_remaining : 16'd0;
        end else if (post.cands[KW_POLL] && post.pos_is4) begin
          res_valid = 1'b0;
        end else begin
          result.response_code = RESP_UNKNOWN;
        end
      end
      PH_RUN0, PH_RUN1, PH_RUN2: begin
        if (post.bad || (post.phase != PH_RUN2)) begin
          result.response_code = RESP_BAD_CMD;
        end else if ((post.accum == 16'd0) || (post.accum > max_seconds)) begin
          result.response_code = RESP_BAD_TIME;
        end else if (same_ids) begin
          if ((last_kind == KIND_RUN) && (last_duration == post.accum)) begin
            result.response_code = RESP_DUP;
            result.session_num   = post.session;
            result.message_num   = post.message;
          end else begin
            result.response_code = RESP_CONFLICT;
          end
        end else begin
          result.response_code = RESP_ACK_RUN;
          result.session_num   = post.session;
          result.message_num   = post.message;
          result.run_seconds   = post.accum;
          result.pump_action   = ACT_START;
          store                = 1'b1;
          store_kind           = KIND_RUN;
        end
      end
      PH_OFF0, PH_OFF1: begin
        if (post.bad || (post.phase != PH_OFF1)) begin
          result.response_code = RESP_BAD_CMD;
        end else if (off_same) begin
          if (last_kind == KIND_OFF) begin
            result.response_code = RESP_DUP;
            result.session_num   = post.session;
            result.message_num   = off_message;
          end else begin
            result.response_code = RESP_CONFLICT;
          end
        end else begin
          result.response_code = RESP_ACK_OFF;
          result.session_num   = post.session;
          result.message_num   = off_message;
          result.pump_action   = ACT_STOP;
          store                = 1'b1;
          store_kind           = KIND_OFF;
        end
      end
      default: begin
        result.response_code = RESP_UNKNOWN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_last     <= 1'b0;
      last_session  <= 16'd0;
      last_message  <= 16'd0;
      last_kind     <= KIND_NONE;
      last_duration <= 16'd0;
    end else if (commit && store) begin
      have_last     <= 1'b1;
      last_session  <= result.session_num;
      last_message  <= result.message_num;
      last_kind     <= store_kind;
      last_duration <= result.run_seconds;
    end
  end

endmodule

FILE: rtl/pump_command_parser_dedup_top.sv
// ----------------------------------------------------------------------------
// Pump command parser with duplicate detection
// Parses a text command packet one byte per transfer and replies at its end.
// ----------------------------------------------------------------------------
// Usage:
//   The in channel carries one packet byte per transfer, with the last-byte
//   flag and the sampled pump state. Text ends at the first zero byte, and
//   bytes beyond the packet length limit are dropped from the text.
//   The out channel carries at most one reply per packet, produced when the
//   byte flagged last is processed. An exact POLL gives no reply.
//   The cfg channel writes the maximum run time in seconds; it is always
//   ready and should only be written while no packet is in flight.
// Data path and throughput:
//   A byte is captured in the input register and goes through the parser and
//   decision logic as it leaves that register; the reply is loaded into the
//   output register when its last byte leaves the input register, so a reply
//   passes through the input and output registers in turn. One byte per cycle
//   is sustained while the receiver keeps up.
// Reset and stalls:
//   Synchronous reset empties both registers, clears the parse state, forgets
//   the last accepted command and sets the maximum run time to 180 seconds.
//   While a reply waits in the output register, a byte in the input register
//   cannot move on and ready stays low; with the input register empty, one
//   more byte is still taken before the input stalls.
// ----------------------------------------------------------------------------
module pump_command_parser_dedup_top import pcd_pkg::*; #(
  parameter int MaxBytes = PCD_MAX_PACKET_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  // Input register holding one accepted byte.
  logic      hold_valid;
  in_item_t  hold;
  // The held byte moves on whenever the output register can take a reply.
  logic      advance;

  logic [15:0] max_seconds;
  parse_t      post;
  logic        res_valid;
  out_item_t   result;

  assign advance   = hold_valid && (!out_valid || out_ready);
  assign in_ready  = !hold_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_seconds <= PCD_MAX_SECONDS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_seconds <= cfg_data;
    end
  end

  // Per-byte parse state; cleared once the last byte has been processed.
  pcd_parser #(
    .MaxBytes (MaxBytes)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .clear    (hold.last_byte),
    .cmd_byte (hold.cmd_byte),
    .post     (post)
  );

  // Reply decision and last-command memory, updated only on a final byte.
  pcd_decide u_decide (
    .clk            (clk),
    .rst            (rst),
    .commit         (advance && hold.last_byte),
    .post           (post),
    .pump_on        (hold.pump_on),
    .pump_remaining (hold.pump_remaining),
    .max_seconds    (max_seconds),
    .res_valid      (res_valid),
    .result         (result)
  );

  // Output register: a reply is loaded on the transfer of a final byte that
  // produces one, and it stays until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && hold.last_byte && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold.last_byte && res_valid) begin
      out_data <= result;
    end
  end

endmodule

FILE: rtl/pcd_checker.sv
// ----------------------------------------------------------------------------
// Pump command parser checker
// Port-level assertions on the reply channel, bound to the top level.
// ----------------------------------------------------------------------------
module pcd_checker import pcd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("reply withdrawn before its transfer");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("reply changed while stalled");

  a_start_is_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.pump_action == ACT_START) |->
      (out_data.response_code == RESP_ACK_RUN) && (out_data.run_seconds != 16'd0))
    else $error("pump start without an acknowledged run");

  a_status_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.response_code == RESP_STATUS) && !out_data.pump_on_report |->
      (out_data.remaining_report == 16'd0))
    else $error("remaining time reported while pump is off");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("reply valid right after reset");

endmodule

bind pump_command_parser_dedup_top pcd_checker u_pcd_checker (.*);
